// File: sv/krt_pkg.sv
// ----------------------------------------------------------------------------
// krt_pkg
// Shared types and constants for the keyed record table.
// ----------------------------------------------------------------------------
package krt_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int KEY_W        = 32;
  localparam int VAL_W        = 8;
  localparam int ENTRIES_W    = 7;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_UPDATE = 2'd2,
    CMD_DUMP   = 2'd3
  } krt_cmd_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_DUP     = 3'd1,
    ST_FULL    = 3'd2,
    ST_MISSING = 3'd3,
    ST_EMPTY   = 3'd4
  } krt_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_SHIFT,
    S_RESP,
    S_DUMP_RD,
    S_DUMP_LD
  } krt_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic        latch;
    logic        rd_en;
    logic        wr_en;
    logic        wr_shift;
    logic        fill_inc;
    logic        fill_dec;
    logic        out_load;
    logic        out_dump;
    logic        out_last;
    krt_status_t status;
  } krt_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic     hit;
    logic     rd_vld;
    logic     out_free;
    krt_cmd_t cmd;
  } krt_sts_t;

endpackage

// File: sv/krt_dp.sv
// ----------------------------------------------------------------------------
// krt_dp
// Datapath: record memory, read pipeline register, key compare, fill count,
// request registers and the result register.
// ----------------------------------------------------------------------------
module krt_dp import krt_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  krt_ctl_t             ctl,
  input  logic [AW-1:0]        rd_addr,
  input  logic [AW-1:0]        wr_addr,
  output krt_sts_t             sts,
  output logic [CW-1:0]        fill,
  output logic [AW-1:0]        rd_idx,
  input  logic [1:0]           in_cmd,
  input  logic signed [KEY_W-1:0] in_key,
  input  logic [VAL_W-1:0]     in_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           out_status,
  output logic signed [KEY_W-1:0] out_key,
  output logic [VAL_W-1:0]     out_value,
  output logic [ENTRIES_W-1:0] out_entries,
  output logic                 out_last
);

  localparam int RW = KEY_W + VAL_W;

  logic [RW-1:0]        mem [CAPACITY];
  logic [RW-1:0]        rdata_r;
  logic [AW-1:0]        rd_idx_r;
  logic                 rd_vld_r;
  logic [CW-1:0]        fill_r;
  krt_cmd_t             cmd_r;
  logic [KEY_W-1:0]     key_r;
  logic [VAL_W-1:0]     value_r;
  logic                 out_valid_r;
  logic [2:0]           out_status_r;
  logic [KEY_W-1:0]     out_key_r;
  logic [VAL_W-1:0]     out_value_r;
  logic [ENTRIES_W-1:0] out_entries_r;
  logic                 out_last_r;
  logic [RW-1:0]        wdata;
  logic                 out_free;

  assign wdata    = ctl.wr_shift ? rdata_r : {key_r, value_r};
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rdata_r  <= mem[rd_addr];
      rd_idx_r <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r    <= 1'b0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r <= ctl.rd_en;
      if (ctl.fill_inc) begin
        fill_r <= fill_r + CW'(1);
      end else if (ctl.fill_dec) begin
        fill_r <= fill_r - CW'(1);
      end
      if (ctl.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cmd_r   <= krt_cmd_t'(in_cmd);
      key_r   <= in_key;
      value_r <= in_value;
    end
    if (ctl.out_load) begin
      out_status_r  <= ctl.status;
      out_key_r     <= ctl.out_dump ? rdata_r[RW-1:VAL_W] : key_r;
      out_value_r   <= ctl.out_dump ? rdata_r[VAL_W-1:0] : '0;
      out_entries_r <= ENTRIES_W'(fill_r);
      out_last_r    <= ctl.out_last;
    end
  end

  assign sts.hit      = rd_vld_r && (rdata_r[RW-1:VAL_W] == key_r);
  assign sts.rd_vld   = rd_vld_r;
  assign sts.out_free = out_free;
  assign sts.cmd      = cmd_r;
  assign fill         = fill_r;
  assign rd_idx       = rd_idx_r;

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_key     = out_key_r;
  assign out_value   = out_value_r;
  assign out_entries = out_entries_r;
  assign out_last    = out_last_r;

endmodule

// File: sv/krt_ctrl.sv
// ----------------------------------------------------------------------------
// krt_ctrl
// Controller: sequences the key scan, the compaction shift after a removal,
// the dump walk and the result handoff.
// ----------------------------------------------------------------------------
module krt_ctrl import krt_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  krt_sts_t      sts,
  input  logic [CW-1:0] fill,
  input  logic [AW-1:0] rd_idx,
  output krt_ctl_t      ctl,
  output logic [AW-1:0] rd_addr,
  output logic [AW-1:0] wr_addr
);

  krt_state_t  state_r, state_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  krt_status_t status_r, status_nxt;
  logic        can_rd;
  logic        dump_last;

  assign can_rd    = idx_r < fill;
  assign dump_last = (idx_r + CW'(1)) == fill;
  assign in_stall  = state_r != S_IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      idx_r    <= '0;
      status_r <= ST_OK;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      status_r <= status_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    status_nxt = status_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        idx_nxt = '0;
        case (sts.cmd)
          CMD_INSERT: begin
            if (fill >= CW'(CAPACITY)) begin
              status_nxt = ST_FULL;
              state_nxt  = S_RESP;
            end else begin
              state_nxt = S_SCAN;
            end
          end
          CMD_DUMP: begin
            if (fill == '0) begin
              status_nxt = ST_EMPTY;
              state_nxt  = S_RESP;
            end else begin
              state_nxt = S_DUMP_RD;
            end
          end
          default: begin
            state_nxt = S_SCAN;
          end
        endcase
      end
      S_SCAN: begin
        if (can_rd && !sts.hit) begin
          idx_nxt = idx_r + CW'(1);
        end
        if (sts.hit) begin
          case (sts.cmd)
            CMD_INSERT: begin
              status_nxt = ST_DUP;
              state_nxt  = S_RESP;
            end
            CMD_REMOVE: begin
              // Compaction starts reading just past the matching record.
              idx_nxt   = CW'(rd_idx) + CW'(1);
              state_nxt = S_SHIFT;
            end
            default: begin
              status_nxt = ST_OK;
              state_nxt  = S_RESP;
            end
          endcase
        end else if (!can_rd && !sts.rd_vld) begin
          status_nxt = (sts.cmd == CMD_INSERT) ? ST_OK : ST_MISSING;
          state_nxt  = S_RESP;
        end
      end
      S_SHIFT: begin
        if (can_rd) begin
          idx_nxt = idx_r + CW'(1);
        end else if (!sts.rd_vld) begin
          status_nxt = ST_OK;
          state_nxt  = S_RESP;
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_DUMP_RD: begin
        state_nxt = S_DUMP_LD;
      end
      S_DUMP_LD: begin
        if (sts.out_free) begin
          if (dump_last) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + CW'(1);
            state_nxt = S_DUMP_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    ctl        = '0;
    ctl.status = ST_OK;
    rd_addr    = idx_r[AW-1:0];
    wr_addr    = fill[AW-1:0];
    case (state_r)
      S_IDLE: begin
        ctl.latch = in_valid;
      end
      S_SCAN: begin
        // No further read once a match is seen, so the read stage is empty
        // when the shift begins.
        ctl.rd_en = can_rd && !sts.hit;
        if (sts.hit && (sts.cmd == CMD_UPDATE)) begin
          ctl.wr_en = 1'b1;
          wr_addr   = rd_idx;
        end else if (!sts.hit && !can_rd && !sts.rd_vld && (sts.cmd == CMD_INSERT)) begin
          ctl.wr_en    = 1'b1;
          ctl.fill_inc = 1'b1;
        end
      end
      S_SHIFT: begin
        ctl.rd_en    = can_rd;
        ctl.wr_en    = sts.rd_vld;
        ctl.wr_shift = 1'b1;
        wr_addr      = rd_idx - AW'(1);
        ctl.fill_dec = !can_rd && !sts.rd_vld;
      end
      S_RESP: begin
        ctl.out_load = sts.out_free;
        ctl.out_last = 1'b1;
        ctl.status   = status_r;
      end
      S_DUMP_RD: begin
        ctl.rd_en = 1'b1;
      end
      S_DUMP_LD: begin
        ctl.out_load = sts.out_free;
        ctl.out_dump = 1'b1;
        ctl.out_last = dump_last;
      end
      default: begin
        ctl.status = ST_OK;
      end
    endcase
  end

endmodule

// File: sv/keyed_record_table.sv
// ----------------------------------------------------------------------------
// keyed_record_table
// Dense table of unique signed keys with small values: insert, remove with
// compaction, update and dump, one command at a time.
// ----------------------------------------------------------------------------
// The key scan reads one entry a cycle for insert, update and remove; a remove
// that hits then compacts the table with one read and one write a cycle. A full
// insert or an empty dump answers without a scan. A dump loads the result for
// each record before it reads the next record. The next command is taken in
// the cycle after the last result is loaded. Reset empties the table at once.
module keyed_record_table import krt_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_cmd,
  input  logic signed [KEY_W-1:0] in_key,
  input  logic [VAL_W-1:0]        in_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [2:0]              out_status,
  output logic signed [KEY_W-1:0] out_key,
  output logic [VAL_W-1:0]        out_value,
  output logic [ENTRIES_W-1:0]    out_entries,
  output logic                    out_last
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  krt_ctl_t      ctl;
  krt_sts_t      sts;
  logic [CW-1:0] fill;
  logic [AW-1:0] rd_idx;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;

  krt_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .fill     (fill),
    .rd_idx   (rd_idx),
    .ctl      (ctl),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr)
  );

  krt_dp #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .rd_addr     (rd_addr),
    .wr_addr     (wr_addr),
    .sts         (sts),
    .fill        (fill),
    .rd_idx      (rd_idx),
    .in_cmd      (in_cmd),
    .in_key      (in_key),
    .in_value    (in_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_status  (out_status),
    .out_key     (out_key),
    .out_value   (out_value),
    .out_entries (out_entries),
    .out_last    (out_last)
  );

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the keyed record table. A scoreboard mirrors the
// table contents, predicts the results of every accepted command, and checks
// each result transfer in order. Directed cases cover the corner cases: an
// empty table, duplicates, missing keys, a full table and compaction on
// remove. Random command mixes follow, with bursts of idling on both sides.
// ----------------------------------------------------------------------------

import krt_pkg::*;

typedef struct packed {
  krt_status_t             status;
  logic signed [KEY_W-1:0] key;
  logic [VAL_W-1:0]        value;
  logic [ENTRIES_W-1:0]    entries;
  logic                    last;
} krt_result_t;

class krt_scoreboard;
  logic signed [KEY_W-1:0] keys [CAPACITY_DEF];
  logic [VAL_W-1:0]        vals [CAPACITY_DEF];
  int                      fill;
  krt_result_t             pending_q [$];
  int                      errors;
  int                      checked;
  int                      cmd_count [4];
  int                      peak_fill;
  int                      full_hits;

  function new();
    fill      = 0;
    errors    = 0;
    checked   = 0;
    peak_fill = 0;
    full_hits = 0;
    foreach (cmd_count[i]) cmd_count[i] = 0;
  endfunction

  function int locate(logic signed [KEY_W-1:0] key);
    for (int i = 0; i < fill; i++) begin
      if (keys[i] == key) return i;
    end
    return -1;
  endfunction

  function logic signed [KEY_W-1:0] pick_key();
    if (fill == 0) return $urandom;
    return keys[$urandom_range(0, fill - 1)];
  endfunction

  function void push_result(krt_status_t status, logic signed [KEY_W-1:0] key,
                            logic [VAL_W-1:0] value, logic last);
    krt_result_t r;
    r.status  = status;
    r.key     = key;
    r.value   = value;
    r.entries = fill[ENTRIES_W-1:0];
    r.last    = last;
    pending_q.push_back(r);
  endfunction

  // Called once per accepted command transfer.
  function void note_input(krt_cmd_t cmd, logic signed [KEY_W-1:0] key,
                           logic [VAL_W-1:0] value);
    int pos;
    cmd_count[cmd]++;
    case (cmd)
      CMD_INSERT: begin
        // The full check takes priority over the duplicate check.
        if (fill >= CAPACITY_DEF) begin
          full_hits++;
          push_result(ST_FULL, key, '0, 1'b1);
        end else if (locate(key) >= 0) begin
          push_result(ST_DUP, key, '0, 1'b1);
        end else begin
          keys[fill] = key;
          vals[fill] = value;
          fill++;
          if (fill > peak_fill) peak_fill = fill;
          push_result(ST_OK, key, '0, 1'b1);
        end
      end
      CMD_REMOVE: begin
        pos = locate(key);
        if (pos < 0) begin
          push_result(ST_MISSING, key, '0, 1'b1);
        end else begin
          for (int i = pos; i + 1 < fill; i++) begin
            keys[i] = keys[i + 1];
            vals[i] = vals[i + 1];
          end
          fill--;
          push_result(ST_OK, key, '0, 1'b1);
        end
      end
      CMD_UPDATE: begin
        pos = locate(key);
        if (pos < 0) begin
          push_result(ST_MISSING, key, '0, 1'b1);
        end else begin
          vals[pos] = value;
          push_result(ST_OK, key, '0, 1'b1);
        end
      end
      default: begin
        if (fill == 0) begin
          push_result(ST_EMPTY, key, '0, 1'b1);
        end else begin
          for (int i = 0; i < fill; i++) begin
            push_result(ST_OK, keys[i], vals[i], (i + 1 == fill));
          end
        end
      end
    endcase
  endfunction

  function void check_result(logic [2:0] status, logic signed [KEY_W-1:0] key,
                             logic [VAL_W-1:0] value, logic [ENTRIES_W-1:0] entries,
                             logic last);
    krt_result_t exp;
    checked++;
    if (pending_q.size() == 0) begin
      $error("unexpected result transfer: status %0d key %0d value %0d entries %0d",
             status, key, value, entries);
      errors++;
      return;
    end
    exp = pending_q.pop_front();
    if (status !== exp.status) begin
      $error("status mismatch: expected %0d, actual %0d", exp.status, status);
      errors++;
    end
    if (key !== exp.key) begin
      $error("out_key mismatch: expected %0d, actual %0d", exp.key, key);
      errors++;
    end
    if (value !== exp.value) begin
      $error("out_value mismatch: expected %0d, actual %0d", exp.value, value);
      errors++;
    end
    if (entries !== exp.entries) begin
      $error("out_entries mismatch: expected %0d, actual %0d", exp.entries, entries);
      errors++;
    end
    if (last !== exp.last) begin
      $error("out_last mismatch: expected %0d, actual %0d", exp.last, last);
      errors++;
    end
  endfunction
endclass

module tb_top;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int TAIL_CYCLES = 300;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic [1:0]              in_cmd;
  logic signed [KEY_W-1:0] in_key;
  logic [VAL_W-1:0]        in_value;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [2:0]              out_status;
  logic signed [KEY_W-1:0] out_key;
  logic [VAL_W-1:0]        out_value;
  logic [ENTRIES_W-1:0]    out_entries;
  logic                    out_last;

  krt_scoreboard sb = new();

  bit quiet;        // no idling on either side in the closing part
  int gap_pct;      // chance of a sender gap after each transfer
  int stall_left = 0;
  int cycles = 0;

  keyed_record_table #(.CAPACITY(CAPACITY_DEF)) DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_cmd      (in_cmd),
    .in_key      (in_key),
    .in_value    (in_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_status  (out_status),
    .out_key     (out_key),
    .out_value   (out_value),
    .out_entries (out_entries),
    .out_last    (out_last)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $error("run exceeded %0d cycles with %0d results outstanding",
             CYCLE_LIMIT, sb.pending_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side backpressure in random bursts.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (!quiet && $urandom_range(0, 99) < 12) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 12);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      sb.check_result(out_status, out_key, out_value, out_entries, out_last);
    end
  end

  // Holds the command until the block takes it, then maybe leaves a gap.
  task automatic send_cmd(krt_cmd_t cmd, logic signed [KEY_W-1:0] key,
                          logic [VAL_W-1:0] value);
    in_valid <= 1'b1;
    in_cmd   <= cmd;
    in_key   <= key;
    in_value <= value;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_input(cmd, key, value);
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
  endtask

  // Random command mix. Most keys come from a small pool or from the table
  // itself so that hits, duplicates and removals happen often.
  task automatic random_ops(int count, int pool_size);
    logic signed [KEY_W-1:0] pool [16];
    logic signed [KEY_W-1:0] key;
    krt_cmd_t                cmd;
    int                      r;
    pool[0] = 32'sh8000_0000;
    pool[1] = 32'sh7fff_ffff;
    pool[2] = '0;
    pool[3] = '1;
    for (int i = 4; i < 16; i++) pool[i] = $urandom;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 35)      cmd = CMD_INSERT;
      else if (r < 62) cmd = CMD_REMOVE;
      else if (r < 88) cmd = CMD_UPDATE;
      else             cmd = CMD_DUMP;
      r = $urandom_range(0, 99);
      if (r < 10)
        key = $urandom;
      else if (cmd != CMD_INSERT && sb.fill > 0 && r < 55)
        key = sb.pick_key();
      else
        key = pool[$urandom_range(0, pool_size - 1)];
      send_cmd(cmd, key, 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_cmd     = CMD_INSERT;
    in_key     = '0;
    in_value   = '0;
    quiet      = 1'b0;
    gap_pct    = 25;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: empty table, extremes, duplicates, misses, compaction.
    send_cmd(CMD_DUMP,   32'sh8000_0000, 8'hff);
    send_cmd(CMD_REMOVE, 32'sh7fff_ffff, 8'h00);
    send_cmd(CMD_UPDATE, 32'sh0000_0000, 8'h11);
    send_cmd(CMD_INSERT, 32'sh8000_0000, 8'h00);
    send_cmd(CMD_INSERT, 32'sh7fff_ffff, 8'hff);
    send_cmd(CMD_INSERT, 32'sh0000_0000, 8'h5a);
    send_cmd(CMD_INSERT, 32'shffff_ffff, 8'ha5);
    send_cmd(CMD_INSERT, 32'sh8000_0000, 8'h07);
    send_cmd(CMD_UPDATE, 32'sh7fff_ffff, 8'h00);
    send_cmd(CMD_UPDATE, 32'shffff_ffff, 8'hff);
    send_cmd(CMD_DUMP,   32'sh1234_5678, 8'h00);
    send_cmd(CMD_REMOVE, 32'sh8000_0000, 8'h00);
    send_cmd(CMD_REMOVE, 32'shffff_ffff, 8'h00);
    send_cmd(CMD_REMOVE, 32'sh0001_2345, 8'h00);
    send_cmd(CMD_DUMP,   32'sh0000_0000, 8'h00);
    send_cmd(CMD_INSERT, 32'sh0000_0000, 8'h33);
    send_cmd(CMD_REMOVE, 32'sh7fff_ffff, 8'h00);
    send_cmd(CMD_REMOVE, 32'sh0000_0000, 8'h00);
    send_cmd(CMD_DUMP,   32'sh7fff_ffff, 8'h00);

    gap_pct = 30;
    random_ops(50, 12);

    // Let everything drain before the fill pass.
    wait_drain();

    gap_pct = 10;
    while (sb.fill < CAPACITY_DEF) send_cmd(CMD_INSERT, $urandom, 8'($urandom_range(0, 255)));
    send_cmd(CMD_INSERT, sb.pick_key(), 8'h01);
    send_cmd(CMD_INSERT, $urandom, 8'h02);
    send_cmd(CMD_DUMP, $urandom, 8'h00);
    send_cmd(CMD_REMOVE, sb.keys[0], 8'h00);
    send_cmd(CMD_REMOVE, sb.keys[sb.fill - 1], 8'h00);
    send_cmd(CMD_REMOVE, sb.keys[sb.fill / 2], 8'h00);
    send_cmd(CMD_UPDATE, sb.keys[10], 8'($urandom_range(0, 255)));
    while (sb.fill < CAPACITY_DEF) send_cmd(CMD_INSERT, $urandom, 8'($urandom_range(0, 255)));
    send_cmd(CMD_INSERT, $urandom, 8'h03);
    send_cmd(CMD_DUMP, $urandom, 8'h00);

    gap_pct = 25;
    random_ops(30, 16);

    // Closing part runs without idling on either side.
    quiet = 1'b1;
    random_ops(15, 8);
    send_cmd(CMD_DUMP, $urandom, 8'h00);

    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sb.pending_q.size() != 0) begin
      $error("%0d expected results never arrived", sb.pending_q.size());
      sb.errors++;
    end
    $display("Ran %0d commands (%0d insert, %0d remove, %0d update, %0d dump), %0d results.",
             sb.cmd_count[0] + sb.cmd_count[1] + sb.cmd_count[2] + sb.cmd_count[3],
             sb.cmd_count[CMD_INSERT], sb.cmd_count[CMD_REMOVE],
             sb.cmd_count[CMD_UPDATE], sb.cmd_count[CMD_DUMP], sb.checked);
    $display("Table peaked at %0d of %0d records; %0d inserts met a full table.",
             sb.peak_fill, CAPACITY_DEF, sb.full_hits);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/krt_pkg.sv
sv/krt_dp.sv
sv/krt_ctrl.sv
sv/keyed_record_table.sv
tb/sv/tb_top.sv
